// ===== rtl/core/zpirf_pkg.sv =====
// Shared types, constants and helpers for the zero-phase IIR record filter.
`default_nettype none

package zpirf_pkg;

  localparam int MAX_SAMPLES = 65536;
  localparam int ORDER       = 4;

  // one b0 term, then b[j] and a[j] for j = 1..ORDER
  localparam int NTERM  = 2 * ORDER + 1;
  localparam int TERM_W = $clog2(NTERM);
  localparam int TAP_W  = $clog2(ORDER + 1);
  localparam int HIST_W = (ORDER > 1) ? $clog2(ORDER) : 1;

  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = ADDR_W + 1;

  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = 16;
  localparam int OUT_W    = 24;
  localparam int OUT_FRAC = 8;
  localparam int COEF_W   = 32;
  localparam int VAL_W    = 40;
  localparam int LO_W     = 16;
  localparam int HI_W     = VAL_W - LO_W;
  localparam int OPND_W   = HI_W + 1;
  localparam int PROD_W   = COEF_W + OPND_W;
  localparam int COEF_FRAC = 28;
  // hi partial product is scaled by 2^LO_W already
  localparam int HI_SHIFT = COEF_FRAC - LO_W;
  localparam int TVAL_W   = PROD_W + 1 - HI_SHIFT;
  localparam int ACC_W    = TVAL_W + TERM_W;

  localparam int NREG       = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = $clog2(NREG) + 3;

  localparam logic [COEF_W-1:0]   B0_RST    = 32'sd2152085;
  localparam logic [2*COEF_W-1:0] B_ODD_RST = 64'd0;
  localparam logic [COEF_W-1:0]   B2_RST    = -32'sd4304172;
  localparam logic [COEF_W-1:0]   B4_RST    = 32'sd2152085;
  localparam logic [COEF_W-1:0]   A1_RST    = -32'sd1000576750;
  localparam logic [COEF_W-1:0]   A2_RST    = 32'sd1400870805;
  localparam logic [COEF_W-1:0]   A3_RST    = -32'sd873622445;
  localparam logic [COEF_W-1:0]   A4_RST    = 32'sd204893902;

  localparam logic STATUS_VALID = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef enum logic {
    CMD_PUSH  = 1'b0,
    CMD_FETCH = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    REG_B0, REG_B_ODD, REG_B2, REG_B4, REG_A1, REG_A2, REG_A3, REG_A4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAC, ST_DRAIN, ST_STORE, ST_BREAD, ST_BLOAD, ST_FREAD, ST_FRESP
  } state_t;

  typedef struct packed {
    logic [4:0][COEF_W-1:0] b;
    logic [4:1][COEF_W-1:0] a;
  } coef_t;

  // one multiplier issue: lo half (unsigned low 16 bits) or hi half of a value
  typedef struct packed {
    logic              valid;
    logic              is_lo;
    logic              has_lo;
    logic              neg;
    logic              first;
    logic [COEF_W-1:0] coef;
    logic [OPND_W-1:0] opnd;
  } mac_op_t;

  function automatic logic [VAL_W-1:0] sat_val(input logic [ACC_W-1:0] v);
    if ((&v[ACC_W-1:VAL_W-1]) || !(|v[ACC_W-1:VAL_W-1])) begin
      return v[VAL_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VAL_W-1){1'b1}}};
    end
  endfunction

  // floor to Q16.8, then saturate to the output width
  function automatic logic [OUT_W-1:0] out_val(input logic [VAL_W-1:0] y);
    logic [VAL_W-OUT_FRAC-1:0] s;
    s = y[VAL_W-1:OUT_FRAC];
    if ((&s[VAL_W-OUT_FRAC-1:OUT_W-1]) || !(|s[VAL_W-OUT_FRAC-1:OUT_W-1])) begin
      return s[OUT_W-1:0];
    end else if (s[VAL_W-OUT_FRAC-1]) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/zpirf_ifs.sv =====
// Valid/ready stream interfaces for the command and result channels.
`default_nettype none

interface zpirf_in_if;
  import zpirf_pkg::*;
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [SAMPLE_W-1:0] sample_in;
  logic                last_in;

  modport source (output valid, cmd, sample_in, last_in, input ready);
  modport sink   (input valid, cmd, sample_in, last_in, output ready);
endinterface

interface zpirf_out_if;
  import zpirf_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] filtered;
  logic [IDX_W-1:0] sample_index;
  logic             last_out;
  logic             status;
  logic             overflow;

  modport source (output valid, filtered, sample_index, last_out, status, overflow,
                  input ready);
  modport sink   (input valid, filtered, sample_index, last_out, status, overflow,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/zpirf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module zpirf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/zpirf_cfg.sv =====
// APB-style coefficient register file.
`default_nettype none

module zpirf_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [zpirf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [zpirf_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [zpirf_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                   pready,
  output zpirf_pkg::coef_t                       coefs
);
  import zpirf_pkg::*;

  logic [COEF_W-1:0]   coef_b0;
  logic [2*COEF_W-1:0] coef_b_odd;
  logic [COEF_W-1:0]   coef_b2;
  logic [COEF_W-1:0]   coef_b4;
  logic [COEF_W-1:0]   coef_a1;
  logic [COEF_W-1:0]   coef_a2;
  logic [COEF_W-1:0]   coef_a3;
  logic [COEF_W-1:0]   coef_a4;
  reg_idx_t            sel;
  logic                wr;

  assign pready = 1'b1;
  assign sel    = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0    <= B0_RST;
      coef_b_odd <= B_ODD_RST;
      coef_b2    <= B2_RST;
      coef_b4    <= B4_RST;
      coef_a1    <= A1_RST;
      coef_a2    <= A2_RST;
      coef_a3    <= A3_RST;
      coef_a4    <= A4_RST;
    end else if (wr) begin
      unique case (sel)
        REG_B0:    coef_b0    <= pwdata[COEF_W-1:0];
        REG_B_ODD: coef_b_odd <= pwdata;
        REG_B2:    coef_b2    <= pwdata[COEF_W-1:0];
        REG_B4:    coef_b4    <= pwdata[COEF_W-1:0];
        REG_A1:    coef_a1    <= pwdata[COEF_W-1:0];
        REG_A2:    coef_a2    <= pwdata[COEF_W-1:0];
        REG_A3:    coef_a3    <= pwdata[COEF_W-1:0];
        REG_A4:    coef_a4    <= pwdata[COEF_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_B0:    prdata = {{COEF_W{1'b0}}, coef_b0};
      REG_B_ODD: prdata = coef_b_odd;
      REG_B2:    prdata = {{COEF_W{1'b0}}, coef_b2};
      REG_B4:    prdata = {{COEF_W{1'b0}}, coef_b4};
      REG_A1:    prdata = {{COEF_W{1'b0}}, coef_a1};
      REG_A2:    prdata = {{COEF_W{1'b0}}, coef_a2};
      REG_A3:    prdata = {{COEF_W{1'b0}}, coef_a3};
      REG_A4:    prdata = {{COEF_W{1'b0}}, coef_a4};
    endcase
  end

  always_comb begin
    coefs.b[0] = coef_b0;
    coefs.b[1] = coef_b_odd[2*COEF_W-1:COEF_W];
    coefs.b[2] = coef_b2;
    coefs.b[3] = coef_b_odd[COEF_W-1:0];
    coefs.b[4] = coef_b4;
    coefs.a[1] = coef_a1;
    coefs.a[2] = coef_a2;
    coefs.a[3] = coef_a3;
    coefs.a[4] = coef_a4;
  end

endmodule

`default_nettype wire

// ===== rtl/core/zpirf_mac.sv =====
// Shared 32x25 multiplier with floor-scaling and accumulator, three stages.
`default_nettype none

module zpirf_mac (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire zpirf_pkg::mac_op_t           op,
  output logic      [zpirf_pkg::ACC_W-1:0]  acc,
  output logic                              busy
);
  import zpirf_pkg::*;

  typedef struct packed {
    logic valid;
    logic is_lo;
    logic has_lo;
    logic neg;
    logic first;
  } tag1_t;

  typedef struct packed {
    logic valid;
    logic neg;
    logic first;
  } tag2_t;

  tag1_t                     tag1;
  tag2_t                     tag2;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  plo;
  logic signed [TVAL_W-1:0]  term;
  logic signed [PROD_W:0]    hsum;
  logic signed [TVAL_W-1:0]  term_next;
  logic signed [ACC_W-1:0]   addend;

  // hi product plus the floored lo product, then floor by 2^12
  always_comb begin
    hsum = {prod[PROD_W-1], prod}
         + (tag1.has_lo ? (PROD_W+1)'(plo >>> LO_W) : '0);
    term_next = TVAL_W'(hsum >>> HI_SHIFT);
    addend = tag2.neg ? -ACC_W'(term) : ACC_W'(term);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
    end else begin
      tag1 <= '{valid: op.valid, is_lo: op.is_lo, has_lo: op.has_lo,
                neg: op.neg, first: op.first};
      tag2 <= '{valid: tag1.valid && !tag1.is_lo, neg: tag1.neg, first: tag1.first};
    end
  end

  always_ff @(posedge clk) begin
    prod <= $signed(op.coef) * $signed(op.opnd);
    if (tag1.valid && tag1.is_lo) begin
      plo <= prod;
    end
    if (tag1.valid && !tag1.is_lo) begin
      term <= term_next;
    end
    if (tag2.valid) begin
      acc <= (tag2.first ? '0 : acc) + addend;
    end
  end

  assign busy = tag1.valid || tag2.valid;

endmodule

`default_nettype wire

// ===== rtl/core/zero_phase_iir_record_filter_top.sv =====
// Top level: record sequencer, filter histories, record store and ports.
//
// Zero-phase order-4 IIR record filter. Push samples with cmd=0 and mark the
// last one with last_in; fetch results with cmd=1, which return one word each
// in forward order. A push runs nine Q4.28 taps through one shared 32x25
// multiplier: the five feedforward terms use only the high half of the 40-bit
// value and the four feedback terms both its low and high halves. After the
// last sample the stored record is filtered backward in place (all nine terms
// use both halves, and each stored sample is read from the store first); the
// input stays not ready until that pass ends. A fetch reads the store and then
// loads the result register once it is free. No clearing pass is run after
// reset. Coefficients must be written only while the block is idle; the
// user must keep to this, as the block itself does not enforce it.
`default_nettype none

module zero_phase_iir_record_filter_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  zpirf_in_if.sink                               din,
  zpirf_out_if.source                            dout,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [zpirf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [zpirf_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [zpirf_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                   pready
);
  import zpirf_pkg::*;

  coef_t               coefs;
  mac_op_t             op;
  logic [ACC_W-1:0]    acc;
  logic                mac_busy;
  logic [VAL_W-1:0]    y_sat;

  state_t              state, state_next;
  logic [TERM_W-1:0]   k, k_next;
  logic                half, half_next;
  logic                bwd, bwd_next;
  logic                last_q, last_q_next;
  logic [VAL_W-1:0]    cur, cur_next;
  logic [VAL_W-1:0]    ff_hist [ORDER];
  logic [VAL_W-1:0]    ff_hist_next [ORDER];
  logic [VAL_W-1:0]    fb_hist [ORDER];
  logic [VAL_W-1:0]    fb_hist_next [ORDER];
  logic [CNT_W-1:0]    count, count_next;
  logic [CNT_W-1:0]    rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]    pos, pos_next;
  logic                pending, pending_next;
  logic                ovf, ovf_next;
  logic                fetch_empty, fetch_empty_next;

  logic                out_valid, out_valid_next;
  logic [OUT_W-1:0]    out_filtered, out_filtered_next;
  logic [IDX_W-1:0]    out_index, out_index_next;
  logic                out_last, out_last_next;
  logic                out_status, out_status_next;
  logic                out_ovf, out_ovf_next;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [VAL_W-1:0]    ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [VAL_W-1:0]    ram_rdata;

  logic [TAP_W-1:0]    tap;
  logic [COEF_W-1:0]   t_coef;
  logic [VAL_W-1:0]    t_val;
  logic                t_ff;
  logic                t_neg;
  logic                accept;
  logic [CNT_W-1:0]    rd_ptr_inc;

  zpirf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coefs   (coefs)
  );

  zpirf_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .op   (op),
    .acc  (acc),
    .busy (mac_busy)
  );

  // forward values, overwritten in place by the final results
  zpirf_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign y_sat      = sat_val(acc);
  assign din.ready  = (state == ST_IDLE);
  assign accept     = din.valid && din.ready;
  assign rd_ptr_inc = rd_ptr + 1'b1;

  assign dout.valid        = out_valid;
  assign dout.filtered     = out_filtered;
  assign dout.sample_index = out_index;
  assign dout.last_out     = out_last;
  assign dout.status       = out_status;
  assign dout.overflow     = out_ovf;

  // term k: b0*cur, then b[j]*ff[j-1] on odd k and a[j]*fb[j-1] on even k
  always_comb begin
    tap   = '0;
    t_ff  = 1'b1;
    t_neg = 1'b0;
    if (k == '0) begin
      t_coef = coefs.b[0];
      t_val  = cur;
    end else if (k[0]) begin
      tap    = TAP_W'((k + 1'b1) >> 1);
      t_coef = coefs.b[tap];
      t_val  = ff_hist[HIST_W'(tap - 1'b1)];
    end else begin
      tap    = TAP_W'(k >> 1);
      t_coef = coefs.a[tap];
      t_val  = fb_hist[HIST_W'(tap - 1'b1)];
      t_ff   = 1'b0;
      t_neg  = 1'b1;
    end
  end

  always_comb begin
    op.valid  = (state == ST_MAC);
    // forward inputs are whole samples: their low half is zero
    op.has_lo = bwd || !t_ff;
    op.is_lo  = op.has_lo && !half;
    op.neg    = t_neg;
    op.first  = (k == '0);
    op.coef   = t_coef;
    op.opnd   = op.is_lo ? {{(OPND_W-LO_W){1'b0}}, t_val[LO_W-1:0]}
                         : {t_val[VAL_W-1], t_val[VAL_W-1:LO_W]};
  end

  always_comb begin
    ram_raddr = (state == ST_FREAD || state == ST_FRESP) ? rd_ptr[ADDR_W-1:0]
                                                         : ADDR_W'(pos - 1'b1);
  end

  always_comb begin
    state_next        = state;
    k_next            = k;
    half_next         = half;
    bwd_next          = bwd;
    last_q_next       = last_q;
    cur_next          = cur;
    ff_hist_next      = ff_hist;
    fb_hist_next      = fb_hist;
    count_next        = count;
    rd_ptr_next       = rd_ptr;
    pos_next          = pos;
    pending_next      = pending;
    ovf_next          = ovf;
    fetch_empty_next  = fetch_empty;
    out_valid_next    = out_valid && !dout.ready;
    out_filtered_next = out_filtered;
    out_index_next    = out_index;
    out_last_next     = out_last;
    out_status_next   = out_status;
    out_ovf_next      = out_ovf;
    ram_we            = 1'b0;
    ram_waddr         = count[ADDR_W-1:0];
    ram_wdata         = y_sat;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_t'(din.cmd) == CMD_FETCH) begin
            fetch_empty_next = !pending;
            state_next       = ST_FREAD;
          end else if (pending) begin
            ovf_next = 1'b1;
          end else if (count == CNT_W'(MAX_SAMPLES)) begin
            // dropped, but a marked last sample still closes the record
            ovf_next = 1'b1;
            if (din.last_in && count != '0) begin
              for (int i = 0; i < ORDER; i++) begin
                ff_hist_next[i] = '0;
                fb_hist_next[i] = '0;
              end
              pos_next   = count;
              bwd_next   = 1'b1;
              state_next = ST_BREAD;
            end
          end else begin
            cur_next    = {{(VAL_W-SAMPLE_W-LO_W){din.sample_in[SAMPLE_W-1]}},
                           din.sample_in, {LO_W{1'b0}}};
            last_q_next = din.last_in;
            bwd_next    = 1'b0;
            k_next      = '0;
            half_next   = 1'b0;
            state_next  = ST_MAC;
          end
        end
      end

      ST_MAC: begin
        if (op.is_lo) begin
          half_next = 1'b1;
        end else begin
          half_next = 1'b0;
          if (k == TERM_W'(NTERM - 1)) begin
            state_next = ST_DRAIN;
          end else begin
            k_next = k + 1'b1;
          end
        end
      end

      ST_DRAIN: begin
        if (!mac_busy) begin
          state_next = ST_STORE;
        end
      end

      ST_STORE: begin
        ram_we = 1'b1;
        for (int i = ORDER - 1; i > 0; i--) begin
          ff_hist_next[i] = ff_hist[i-1];
          fb_hist_next[i] = fb_hist[i-1];
        end
        ff_hist_next[0] = cur;
        fb_hist_next[0] = y_sat;
        if (!bwd) begin
          count_next = count + 1'b1;
          if (last_q) begin
            for (int i = 0; i < ORDER; i++) begin
              ff_hist_next[i] = '0;
              fb_hist_next[i] = '0;
            end
            pos_next   = count + 1'b1;
            bwd_next   = 1'b1;
            state_next = ST_BREAD;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          ram_waddr = ADDR_W'(pos - 1'b1);
          ram_wdata = VAL_W'(out_val(y_sat));
          pos_next  = pos - 1'b1;
          if (pos == CNT_W'(1)) begin
            for (int i = 0; i < ORDER; i++) begin
              ff_hist_next[i] = '0;
              fb_hist_next[i] = '0;
            end
            pending_next = 1'b1;
            rd_ptr_next  = '0;
            bwd_next     = 1'b0;
            state_next   = ST_IDLE;
          end else begin
            state_next = ST_BREAD;
          end
        end
      end

      ST_BREAD: begin
        state_next = ST_BLOAD;
      end

      ST_BLOAD: begin
        cur_next   = ram_rdata;
        k_next     = '0;
        half_next  = 1'b0;
        state_next = ST_MAC;
      end

      ST_FREAD: begin
        state_next = ST_FRESP;
      end

      ST_FRESP: begin
        if (!out_valid || dout.ready) begin
          out_valid_next = 1'b1;
          out_ovf_next   = ovf;
          if (fetch_empty) begin
            out_filtered_next = '0;
            out_index_next    = '0;
            out_last_next     = 1'b0;
            out_status_next   = STATUS_EMPTY;
          end else begin
            out_filtered_next = ram_rdata[OUT_W-1:0];
            out_index_next    = IDX_W'(rd_ptr);
            out_last_next     = (rd_ptr_inc == count);
            out_status_next   = STATUS_VALID;
            rd_ptr_next       = rd_ptr_inc;
            if (rd_ptr_inc >= count) begin
              pending_next = 1'b0;
              count_next   = '0;
              rd_ptr_next  = '0;
            end
          end
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      k         <= '0;
      half      <= 1'b0;
      bwd       <= 1'b0;
      count     <= '0;
      rd_ptr    <= '0;
      pos       <= '0;
      pending   <= 1'b0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < ORDER; i++) begin
        ff_hist[i] <= '0;
        fb_hist[i] <= '0;
      end
    end else begin
      state     <= state_next;
      k         <= k_next;
      half      <= half_next;
      bwd       <= bwd_next;
      count     <= count_next;
      rd_ptr    <= rd_ptr_next;
      pos       <= pos_next;
      pending   <= pending_next;
      ovf       <= ovf_next;
      out_valid <= out_valid_next;
      ff_hist   <= ff_hist_next;
      fb_hist   <= fb_hist_next;
    end
  end

  always_ff @(posedge clk) begin
    last_q       <= last_q_next;
    cur          <= cur_next;
    fetch_empty  <= fetch_empty_next;
    out_filtered <= out_filtered_next;
    out_index    <= out_index_next;
    out_last     <= out_last_next;
    out_status   <= out_status_next;
    out_ovf      <= out_ovf_next;
  end

endmodule

`default_nettype wire
